/* rtl/assert_macros.svh */
// Assertion helpers shared by the capability table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/ctll_pkg.sv */
`timescale 1ns / 1ps

package ctll_pkg;

  // Beat field widths
  localparam int OP_W  = 2;
  localparam int PID_W = 3;
  localparam int IDX_W = 5;
  localparam int CAP_W = 64;

  // Request codes
  typedef enum logic [OP_W-1:0] {
    OP_READ   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_MOVE   = 2'd3
  } opcode_t;

  // Port controls from the sequencer to the slot store
  typedef struct packed {
    logic rd_en;    // read word, prev and next at the slot address
    logic nrd_en;   // read next link only
    logic cap_we;
    logic prev_we;
    logic next_we;
  } store_ctl_t;

endpackage

/* rtl/ctll_if.sv */
`timescale 1ns / 1ps

interface ctll_req_if;
  logic                        valid;
  logic                        ready;
  logic [ctll_pkg::OP_W-1:0]   opcode;
  logic [ctll_pkg::PID_W-1:0]  slot_pid;
  logic [ctll_pkg::IDX_W-1:0]  slot_index;
  logic [ctll_pkg::PID_W-1:0]  other_pid;
  logic [ctll_pkg::IDX_W-1:0]  other_index;
  logic [ctll_pkg::CAP_W-1:0]  cap_in;

  modport source (
    output valid, opcode, slot_pid, slot_index, other_pid, other_index, cap_in,
    input  ready
  );
  modport sink (
    input  valid, opcode, slot_pid, slot_index, other_pid, other_index, cap_in,
    output ready
  );
endinterface

interface ctll_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ctll_pkg::CAP_W-1:0]  cap_out;
  logic                        slot_empty;
  logic [ctll_pkg::PID_W-1:0]  prev_pid;
  logic [ctll_pkg::IDX_W-1:0]  prev_index;
  logic [ctll_pkg::PID_W-1:0]  next_pid;
  logic [ctll_pkg::IDX_W-1:0]  next_index;
  logic                        status;

  modport source (
    output valid, cap_out, slot_empty, prev_pid, prev_index, next_pid, next_index,
           status,
    input  ready
  );
  modport sink (
    input  valid, cap_out, slot_empty, prev_pid, prev_index, next_pid, next_index,
           status,
    output ready
  );
endinterface

/* rtl/capability_table_linked_list.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel  Modport  Beat contents
// req      sink     opcode, slot_pid/index, other_pid/index, cap_in
// rsp      source   cap_out, slot_empty, prev/next pid and index, status
//
// Each request steps through accept with slot read, link read of the other
// slot, then the two write states WR1 and WR2 on the single write port of each
// store array. A new request is taken the cycle after the result is registered.
// After reset a sweep clears the store, one row a cycle, all 2**(PW+IW) rows
// (256 with default sizes); req.ready stays low until it ends.
// A stalled rsp holds the finished result; the sequencer waits in HOLD.
module capability_table_linked_list #(
  parameter int PROC_COUNT     = 8,
  parameter int SLOTS_PER_PROC = 32,
  parameter int CAP_TYPE_BITS  = 8
) (
  input  logic          clk,
  input  logic          rst,
  ctll_req_if.sink      req,
  ctll_rsp_if.source    rsp
);

  localparam int PW    = (PROC_COUNT > 1) ? $clog2(PROC_COUNT) : 1;
  localparam int IW    = (SLOTS_PER_PROC > 1) ? $clog2(SLOTS_PER_PROC) : 1;
  localparam int AW    = PW + IW;
  localparam int CW    = ctll_pkg::CAP_W;
  localparam int PID_W = ctll_pkg::PID_W;
  localparam int IDX_W = ctll_pkg::IDX_W;
  localparam int RW    = 9;  // compare width covering every range limit

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_WR1  = 5'b00100,
    S_WR2  = 5'b01000,
    S_HOLD = 5'b10000
  } state_t;

  state_t                state, state_next;
  ctll_pkg::store_ctl_t  ctl;
  ctll_pkg::opcode_t     op_in, op_r;
  logic                  busy, accept, out_free, load_out;
  logic                  slot_ok, other_ok, need_other, bad_in, bad_r, is_mv;
  logic [AW-1:0]         c_in, o_in, c_r, o_r, pc, nc, nxo;
  logic [AW-1:0]         nrd_addr, cap_waddr, prev_waddr, prev_wdata;
  logic [AW-1:0]         next_waddr, next_wdata, prev_q, next_q;
  logic [CW-1:0]         cap_r, capc, cap_wdata, cap_q;

  logic                  out_valid, out_empty, out_status;
  logic [CW-1:0]         out_cap;
  logic [PID_W-1:0]      out_ppid, out_npid;
  logic [IDX_W-1:0]      out_pidx, out_nidx;

  // Decode and range-check the request beat
  assign op_in      = ctll_pkg::opcode_t'(req.opcode);
  assign need_other = (op_in == ctll_pkg::OP_INSERT) || (op_in == ctll_pkg::OP_MOVE);
  assign slot_ok    = (RW'(req.slot_pid) < RW'(PROC_COUNT)) &&
                      (RW'(req.slot_index) < RW'(SLOTS_PER_PROC));
  assign other_ok   = (RW'(req.other_pid) < RW'(PROC_COUNT)) &&
                      (RW'(req.other_index) < RW'(SLOTS_PER_PROC));
  assign bad_in     = !slot_ok || (need_other && !other_ok);
  assign c_in       = {PW'(req.slot_pid), IW'(req.slot_index)};
  assign o_in       = {PW'(req.other_pid), IW'(req.other_index)};

  assign req.ready  = (state == S_IDLE) && !busy;
  assign accept     = req.valid && req.ready;
  assign out_free   = !out_valid || rsp.ready;
  assign load_out   = ((state == S_WR2) || (state == S_HOLD)) && out_free;
  assign is_mv      = (op_r == ctll_pkg::OP_MOVE) && (c_r != o_r);

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_RD;
      S_RD:    state_next = S_WR1;
      S_WR1:   state_next = S_WR2;
      S_WR2:   state_next = out_free ? S_IDLE : S_HOLD;
      S_HOLD:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Latch the request and the slot contents read back
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_in;
      c_r   <= c_in;
      o_r   <= o_in;
      cap_r <= req.cap_in;
      bad_r <= bad_in;
    end
    if (state == S_RD) begin
      capc <= cap_q;
      pc   <= prev_q;
      nc   <= next_q;
    end
    if (state == S_WR1) begin
      nxo <= next_q;
    end
  end

  // Store port control: reads at accept and RD, word and link writes in WR1 and WR2
  always_comb begin
    ctl            = '0;
    ctl.rd_en      = accept;
    ctl.nrd_en     = (state == S_RD);
    nrd_addr       = (state == S_RD) ? o_r : c_in;
    cap_waddr      = c_r;
    cap_wdata      = '0;
    prev_waddr     = c_r;
    prev_wdata     = c_r;
    next_waddr     = c_r;
    next_wdata     = c_r;
    if (!bad_r) begin
      case (state)
        S_WR1: begin
          case (op_r)
            ctll_pkg::OP_INSERT: begin
              ctl.cap_we  = 1'b1;
              cap_wdata   = cap_r;
              ctl.prev_we = 1'b1;
              prev_wdata  = o_r;
              ctl.next_we = 1'b1;
              next_wdata  = next_q;
            end
            ctll_pkg::OP_DELETE: begin
              ctl.cap_we  = 1'b1;
              ctl.next_we = 1'b1;
              next_waddr  = pc;
              next_wdata  = nc;
            end
            ctll_pkg::OP_MOVE: begin
              if (is_mv) begin
                ctl.cap_we  = 1'b1;
                cap_waddr   = o_r;
                cap_wdata   = capc;
                ctl.prev_we = 1'b1;
                prev_waddr  = o_r;
                prev_wdata  = pc;
                ctl.next_we = 1'b1;
                next_waddr  = o_r;
                next_wdata  = nc;
              end
            end
            default: ;
          endcase
        end
        S_WR2: begin
          case (op_r)
            ctll_pkg::OP_INSERT: begin
              // predecessor points forward to us; successor back to us
              ctl.next_we = 1'b1;
              next_waddr  = o_r;
              next_wdata  = c_r;
              ctl.prev_we = 1'b1;
              prev_waddr  = (o_r == c_r) ? c_r : nxo;
              prev_wdata  = c_r;
            end
            ctll_pkg::OP_DELETE: begin
              ctl.prev_we = 1'b1;
              prev_waddr  = nc;
              prev_wdata  = pc;
            end
            ctll_pkg::OP_MOVE: begin
              if (is_mv) begin
                ctl.cap_we  = 1'b1;
                cap_waddr   = c_r;
                ctl.next_we = 1'b1;
                next_waddr  = pc;
                next_wdata  = o_r;
                ctl.prev_we = 1'b1;
                prev_waddr  = (pc == o_r) ? o_r : nc;
                prev_wdata  = o_r;
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  ctll_store #(
    .AW (AW)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .rd_addr    (c_in),
    .nrd_addr   (nrd_addr),
    .cap_waddr  (cap_waddr),
    .cap_wdata  (cap_wdata),
    .prev_waddr (prev_waddr),
    .prev_wdata (prev_wdata),
    .next_waddr (next_waddr),
    .next_wdata (next_wdata),
    .cap_q      (cap_q),
    .prev_q     (prev_q),
    .next_q     (next_q),
    .busy       (busy)
  );

  // Result register: hold until the rsp beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status <= bad_r;
      out_cap    <= bad_r ? '0 : capc;
      out_empty  <= !bad_r && (capc[CAP_TYPE_BITS-1:0] == '0);
      out_ppid   <= bad_r ? '0 : PID_W'(pc[AW-1:IW]);
      out_pidx   <= bad_r ? '0 : IDX_W'(pc[IW-1:0]);
      out_npid   <= bad_r ? '0 : PID_W'(nc[AW-1:IW]);
      out_nidx   <= bad_r ? '0 : IDX_W'(nc[IW-1:0]);
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.cap_out    = out_cap;
  assign rsp.slot_empty = out_empty;
  assign rsp.prev_pid   = out_ppid;
  assign rsp.prev_index = out_pidx;
  assign rsp.next_pid   = out_npid;
  assign rsp.next_index = out_nidx;
  assign rsp.status     = out_status;

  `ASSERT_NEXT(a_accept_rd, clk, rst, accept, state == S_RD)
  `ASSERT_IMPL(a_no_wr_clr, clk, rst, busy, !ctl.cap_we && !ctl.prev_we && !ctl.next_we)
  `ASSERT_IMPL(a_bad_zero, clk, rst, out_valid && out_status, out_cap == '0 && !out_empty && out_ppid == '0 && out_nidx == '0)

endmodule

/* rtl/ctll_store.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ctll_store #(
  parameter int AW = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  ctll_pkg::store_ctl_t       ctl,
  input  logic [AW-1:0]              rd_addr,
  input  logic [AW-1:0]              nrd_addr,
  input  logic [AW-1:0]              cap_waddr,
  input  logic [ctll_pkg::CAP_W-1:0] cap_wdata,
  input  logic [AW-1:0]              prev_waddr,
  input  logic [AW-1:0]              prev_wdata,
  input  logic [AW-1:0]              next_waddr,
  input  logic [AW-1:0]              next_wdata,
  output logic [ctll_pkg::CAP_W-1:0] cap_q,
  output logic [AW-1:0]              prev_q,
  output logic [AW-1:0]              next_q,
  output logic                       busy
);

  localparam int DEPTH = 1 << AW;

  logic [ctll_pkg::CAP_W-1:0] cap_mem  [DEPTH];
  logic [AW-1:0]              prev_mem [DEPTH];
  logic [AW-1:0]              next_mem [DEPTH];
  logic [AW-1:0]              clr_ptr;

  // Sweep every row to zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_ptr <= '0;
    end else if (busy) begin
      clr_ptr <= clr_ptr + AW'(1);
      if (&clr_ptr) begin
        busy <= 1'b0;
      end
    end
  end

  // Write ports: the clearing sweep owns them while busy
  always_ff @(posedge clk) begin
    if (busy) begin
      cap_mem[clr_ptr]  <= '0;
      prev_mem[clr_ptr] <= '0;
      next_mem[clr_ptr] <= '0;
    end else begin
      if (ctl.cap_we) begin
        cap_mem[cap_waddr] <= cap_wdata;
      end
      if (ctl.prev_we) begin
        prev_mem[prev_waddr] <= prev_wdata;
      end
      if (ctl.next_we) begin
        next_mem[next_waddr] <= next_wdata;
      end
    end
  end

  // Registered read ports
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      cap_q  <= cap_mem[rd_addr];
      prev_q <= prev_mem[rd_addr];
    end
    if (ctl.rd_en || ctl.nrd_en) begin
      next_q <= next_mem[nrd_addr];
    end
  end

  `ASSERT_NEXT(a_clr_step, clk, rst, busy && !(&clr_ptr), busy && clr_ptr == $past(clr_ptr) + AW'(1))
  `ASSERT_NEXT(a_clr_end, clk, rst, busy && (&clr_ptr), !busy)

endmodule

/* sim/capability_table_checker.sv */
`timescale 1ns / 1ps

module capability_table_checker (
  input  logic clk,
  input  logic rst,
  ctll_req_if  req,
  ctll_rsp_if  rsp,
  output int   errors,
  output int   pending
);

  localparam int PID_W          = ctll_pkg::PID_W;
  localparam int IDX_W          = ctll_pkg::IDX_W;
  localparam int CAP_W          = ctll_pkg::CAP_W;
  localparam int PROC_COUNT     = 8;
  localparam int SLOTS_PER_PROC = 32;
  localparam int CAP_TYPE_BITS  = 8;
  localparam int SLOT_COUNT     = PROC_COUNT * SLOTS_PER_PROC;
  localparam int SLOT_W         = PID_W + IDX_W;
  localparam int MAX_PRINTED    = 100;

  typedef struct {
    logic [CAP_W-1:0] cap_out;
    logic             slot_empty;
    logic [PID_W-1:0] prev_pid;
    logic [IDX_W-1:0] prev_index;
    logic [PID_W-1:0] next_pid;
    logic [IDX_W-1:0] next_index;
    logic             status;
  } rsp_beat_t;

  // Shadow copy of the slot table
  logic [CAP_W-1:0]  cap_word  [SLOT_COUNT];
  logic [SLOT_W-1:0] prev_slot [SLOT_COUNT];
  logic [SLOT_W-1:0] next_slot [SLOT_COUNT];

  rsp_beat_t awaited_rsp [$];
  int        mismatch_count = 0;
  int        rsp_beats = 0;

  task automatic report_mismatch(string what, logic [CAP_W-1:0] got, logic [CAP_W-1:0] want);
    if (mismatch_count < MAX_PRINTED)
      $display("%0t: result beat %0d, %s: got %h, want %h", $time, rsp_beats, what, got, want);
    mismatch_count++;
  endtask

  function automatic logic [SLOT_W-1:0] flat_slot(logic [PID_W-1:0] pid, logic [IDX_W-1:0] idx);
    return SLOT_W'(int'(pid) * SLOTS_PER_PROC + int'(idx));
  endfunction

  // Apply one request to the shadow table and return the result it should give
  function automatic rsp_beat_t run_table_op(ctll_pkg::opcode_t op, logic [PID_W-1:0] sp,
                                             logic [IDX_W-1:0] si, logic [PID_W-1:0] op_pid,
                                             logic [IDX_W-1:0] op_idx, logic [CAP_W-1:0] cap);
    rsp_beat_t         r;
    logic [SLOT_W-1:0] c;
    logic [SLOT_W-1:0] o;
    logic [SLOT_W-1:0] p;
    logic [SLOT_W-1:0] n;
    logic              need_other;
    r = '{default: '0};
    need_other = (op == ctll_pkg::OP_INSERT) || (op == ctll_pkg::OP_MOVE);
    if (int'(sp) >= PROC_COUNT || int'(si) >= SLOTS_PER_PROC ||
        (need_other && (int'(op_pid) >= PROC_COUNT || int'(op_idx) >= SLOTS_PER_PROC))) begin
      r.status = 1'b1;
      return r;
    end
    c = flat_slot(sp, si);
    o = need_other ? flat_slot(op_pid, op_idx) : '0;
    p = prev_slot[c];
    n = next_slot[c];
    r.cap_out    = cap_word[c];
    r.slot_empty = (cap_word[c][CAP_TYPE_BITS-1:0] == '0);
    r.prev_pid   = PID_W'(int'(p) / SLOTS_PER_PROC);
    r.prev_index = IDX_W'(int'(p) % SLOTS_PER_PROC);
    r.next_pid   = PID_W'(int'(n) / SLOTS_PER_PROC);
    r.next_index = IDX_W'(int'(n) % SLOTS_PER_PROC);
    case (op)
      ctll_pkg::OP_INSERT: begin
        // link after the predecessor, step by step so self-insert loops back
        prev_slot[c] = o;
        next_slot[c] = next_slot[o];
        next_slot[prev_slot[c]] = c;
        prev_slot[next_slot[c]] = c;
        cap_word[c] = cap;
      end
      ctll_pkg::OP_DELETE: begin
        cap_word[c] = '0;
        next_slot[prev_slot[c]] = next_slot[c];
        prev_slot[next_slot[c]] = prev_slot[c];
      end
      ctll_pkg::OP_MOVE: begin
        if (c != o) begin
          cap_word[o]  = cap_word[c];
          cap_word[c]  = '0;
          prev_slot[o] = prev_slot[c];
          next_slot[o] = next_slot[c];
          next_slot[prev_slot[o]] = o;
          prev_slot[next_slot[o]] = o;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Predict on every request beat, compare on every result beat
  always @(posedge clk) begin
    rsp_beat_t want;
    if (rst) begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
        cap_word[k]  = '0;
        prev_slot[k] = '0;
        next_slot[k] = '0;
      end
      awaited_rsp.delete();
    end else begin
      if (req.valid && req.ready)
        awaited_rsp.push_back(run_table_op(ctll_pkg::opcode_t'(req.opcode), req.slot_pid,
                                           req.slot_index, req.other_pid, req.other_index,
                                           req.cap_in));
      if (rsp.valid && rsp.ready) begin
        if (awaited_rsp.size() == 0) begin
          report_mismatch("no request waiting", rsp.cap_out, '0);
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.cap_out !== want.cap_out)
            report_mismatch("cap_out", rsp.cap_out, want.cap_out);
          if (rsp.slot_empty !== want.slot_empty)
            report_mismatch("slot_empty", CAP_W'(rsp.slot_empty), CAP_W'(want.slot_empty));
          if (rsp.prev_pid !== want.prev_pid)
            report_mismatch("prev_pid", CAP_W'(rsp.prev_pid), CAP_W'(want.prev_pid));
          if (rsp.prev_index !== want.prev_index)
            report_mismatch("prev_index", CAP_W'(rsp.prev_index), CAP_W'(want.prev_index));
          if (rsp.next_pid !== want.next_pid)
            report_mismatch("next_pid", CAP_W'(rsp.next_pid), CAP_W'(want.next_pid));
          if (rsp.next_index !== want.next_index)
            report_mismatch("next_index", CAP_W'(rsp.next_index), CAP_W'(want.next_index));
          if (rsp.status !== want.status)
            report_mismatch("status", CAP_W'(rsp.status), CAP_W'(want.status));
        end
        rsp_beats++;
      end
    end
    errors  <= mismatch_count;
    pending <= awaited_rsp.size();
  end

endmodule

/* sim/capability_table_linked_list_tb.sv */
`timescale 1ns / 1ps

module capability_table_linked_list_tb;

  localparam int PID_W         = ctll_pkg::PID_W;
  localparam int IDX_W         = ctll_pkg::IDX_W;
  localparam int CAP_W         = ctll_pkg::CAP_W;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int CAP_TYPE_BITS = 8;
  localparam int IDLE_PCT      = 23;

  logic clk = 1'b0;
  logic rst;
  logic calm;
  int   fail_count;
  int   leftover;
  int   sent_by_op [4];

  ctll_req_if req ();
  ctll_rsp_if rsp ();

  capability_table_linked_list dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  capability_table_checker chk (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .errors  (fail_count),
    .pending (leftover)
  );

  always #5 clk = ~clk;

  // Stall the result side at random unless in a calm stretch
  always @(posedge clk) begin
    rsp.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  initial begin
    #2_000_000;
    $display("capability_table_linked_list_tb: errors");
    $finish;
  end

  // Offer one request beat, with random idle cycles ahead of it
  task automatic send_req(ctll_pkg::opcode_t op, logic [PID_W-1:0] sp, logic [IDX_W-1:0] si,
                          logic [PID_W-1:0] op_pid, logic [IDX_W-1:0] op_idx,
                          logic [CAP_W-1:0] cap);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.opcode      <= op;
    req.slot_pid    <= sp;
    req.slot_index  <= si;
    req.other_pid   <= op_pid;
    req.other_index <= op_idx;
    req.cap_in      <= cap;
    do @(posedge clk); while (!req.ready);
    sent_by_op[op]++;
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic wait_drained();
    req.valid <= 1'b0;
    do @(posedge clk); while (leftover != 0);
  endtask

  // Mostly a small cluster of slots so list operations keep hitting each other
  function automatic logic [PID_W+IDX_W-1:0] pick_slot();
    if ($urandom_range(3) != 0)
      return {PID_W'($urandom_range(1)), IDX_W'($urandom_range(5))};
    return (PID_W+IDX_W)'($urandom);
  endfunction

  initial begin
    logic [PID_W+IDX_W-1:0] s;
    logic [PID_W+IDX_W-1:0] t;
    logic [CAP_W-1:0]       cap;
    foreach (sent_by_op[k]) sent_by_op[k] = 0;
    rst             <= 1'b1;
    calm            <= 1'b0;
    req.valid       <= 1'b0;
    req.opcode      <= ctll_pkg::OP_READ;
    req.slot_pid    <= '0;
    req.slot_index  <= '0;
    req.other_pid   <= '0;
    req.other_index <= '0;
    req.cap_in      <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: corners of the fields and the list special cases
    send_req(ctll_pkg::OP_READ,   3'd0, 5'd0,  3'd7, 5'd31, '1);
    send_req(ctll_pkg::OP_INSERT, 3'd0, 5'd1,  3'd0, 5'd0,  64'hFFFF_FFFF_FFFF_FFFF);
    send_req(ctll_pkg::OP_INSERT, 3'd7, 5'd31, 3'd0, 5'd1,  64'hFFFF_FFFF_FFFF_FF00);
    send_req(ctll_pkg::OP_READ,   3'd0, 5'd1,  3'd0, 5'd0,  '0);
    send_req(ctll_pkg::OP_READ,   3'd7, 5'd31, 3'd0, 5'd0,  '0);
    // insert a slot after itself
    send_req(ctll_pkg::OP_INSERT, 3'd3, 5'd5,  3'd3, 5'd5,  64'h0123_4567_89AB_CDEF);
    send_req(ctll_pkg::OP_READ,   3'd3, 5'd5,  3'd0, 5'd0,  '0);
    send_req(ctll_pkg::OP_MOVE,   3'd0, 5'd1,  3'd2, 5'd2,  '0);
    // move a slot onto itself
    send_req(ctll_pkg::OP_MOVE,   3'd2, 5'd2,  3'd2, 5'd2,  '1);
    send_req(ctll_pkg::OP_READ,   3'd2, 5'd2,  3'd0, 5'd0,  '0);
    send_req(ctll_pkg::OP_READ,   3'd0, 5'd1,  3'd0, 5'd0,  '0);
    send_req(ctll_pkg::OP_INSERT, 3'd5, 5'd17, 3'd2, 5'd2,  64'h8000_0000_0000_0001);
    // move and insert over occupied slots
    send_req(ctll_pkg::OP_MOVE,   3'd5, 5'd17, 3'd7, 5'd31, '0);
    send_req(ctll_pkg::OP_INSERT, 3'd7, 5'd31, 3'd0, 5'd0,  64'h5555_5555_5555_5555);
    send_req(ctll_pkg::OP_DELETE, 3'd2, 5'd2,  3'd0, 5'd0,  '0);
    send_req(ctll_pkg::OP_READ,   3'd2, 5'd2,  3'd0, 5'd0,  '0);
    send_req(ctll_pkg::OP_DELETE, 3'd3, 5'd5,  3'd0, 5'd0,  '0);
    // delete and move slots that were never written
    send_req(ctll_pkg::OP_DELETE, 3'd4, 5'd9,  3'd0, 5'd0,  '0);
    send_req(ctll_pkg::OP_MOVE,   3'd6, 5'd30, 3'd1, 5'd1,  '0);
    send_req(ctll_pkg::OP_READ,   3'd7, 5'd31, 3'd0, 5'd0,  '0);
    send_req(ctll_pkg::OP_DELETE, 3'd0, 5'd0,  3'd7, 5'd31, '1);
    send_req(ctll_pkg::OP_READ,   3'd0, 5'd0,  3'd7, 5'd31, '1);
    wait_drained();

    // Random: clustered list traffic, with a calm stretch and a mid-run drain
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm <= (i >= 400 && i < 600);
      if (i == 800)
        wait_drained();
      s = pick_slot();
      t = pick_slot();
      cap = {$urandom, $urandom};
      if ($urandom_range(4) == 0)
        cap[CAP_TYPE_BITS-1:0] = '0;
      send_req(ctll_pkg::opcode_t'($urandom_range(3)), s[PID_W+IDX_W-1:IDX_W], s[IDX_W-1:0],
               t[PID_W+IDX_W-1:IDX_W], t[IDX_W-1:0], cap);
    end
    wait_drained();
    repeat (16) @(posedge clk);

    $display("covered %0d reads, %0d inserts, %0d deletes, %0d moves on the linked slot table",
             sent_by_op[ctll_pkg::OP_READ], sent_by_op[ctll_pkg::OP_INSERT],
             sent_by_op[ctll_pkg::OP_DELETE], sent_by_op[ctll_pkg::OP_MOVE]);
    $display("with random stalls on both channels, a calm stretch and three full drains");
    if (fail_count == 0 && leftover == 0) begin
      $display("capability_table_linked_list_tb: clean");
    end else begin
      $display("capability_table_linked_list_tb: errors");
    end
    $finish;
  end

endmodule
